// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros sample on clk and are quiet while rst is high.

// Checks that an expression holds at every clock edge.
`define AST_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that a condition is followed in the next cycle by a consequence.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/phr_pkg.sv
`default_nettype none

package phr_pkg;

  // Channel width and quotient width of the interpolation.
  localparam int CW = 8;
  localparam int QW = 8;

  // Hue in units of 1/255 degree: new_hue * 360 fits in 17 bits.
  localparam int HW = 17;
  localparam int HUE_SCALE = 360;

  // Product of an 8-bit channel difference and a 17-bit hue term.
  localparam int REM_W = CW + HW;

  // Quotient bits resolved per divider stage.
  localparam int BPS = 2;
  localparam int DIV_STAGES = QW / BPS;

  localparam logic [HW-1:0] D60  = HW'(60 * 255);
  localparam logic [HW-1:0] D120 = HW'(120 * 255);
  localparam logic [HW-1:0] D180 = HW'(180 * 255);
  localparam logic [HW-1:0] D240 = HW'(240 * 255);
  localparam logic [HW-1:0] D300 = HW'(300 * 255);
  localparam logic [HW-1:0] D360 = HW'(360 * 255);

  // Configuration register indexes.
  localparam logic [1:0] REG_NEW_HUE     = 2'd0;
  localparam logic [1:0] REG_RANGE_FIRST = 2'd1;
  localparam logic [1:0] REG_RANGE_LAST  = 2'd2;

  // Hue sectors of 60 degrees each.
  typedef enum logic [2:0] {
    SEC_RED_UP,
    SEC_GREEN_DOWN,
    SEC_GREEN_UP,
    SEC_BLUE_DOWN,
    SEC_BLUE_UP,
    SEC_RED_DOWN
  } sector_t;

  // Payload that travels down the pipeline next to its valid bit.
  typedef struct packed {
    logic             pass;
    logic [CW-1:0]    r;
    logic [CW-1:0]    g;
    logic [CW-1:0]    b;
    logic [CW-1:0]    mx;
    logic [CW-1:0]    mn;
    logic [CW-1:0]    diff;
    logic [REM_W-1:0] rem;
    logic [QW-1:0]    q;
  } pipe_t;

endpackage

`default_nettype wire

// File: sv/palette_hue_replace.sv
// A taken input beat is registered in stage 0, stage 1, the divider stages and then the output register.
// Throughput: one beat per cycle; a stalled output freezes every stage, so nothing is lost.
// Depth is set by max/min, one 8x17 multiply and four divider stages of two quotient bits.
// Reset (rst, synchronous, active high) empties the pipeline and sets new_hue to 0,
// range_first to 0 and range_last to 255.
`default_nettype none

module palette_hue_replace (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           entry_index,
  input  wire logic [7:0]           red_in,
  input  wire logic [7:0]           green_in,
  input  wire logic [7:0]           blue_in,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                red_out,
  output logic [7:0]                green_out,
  output logic [7:0]                blue_out,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [7:0]           cfg_data
);
  import phr_pkg::*;

  localparam int NSTG = 2 + DIV_STAGES;

  // Registers decoded from the hue at write time, and the entry range.
  sector_t       sector;
  logic [HW-1:0] num;
  logic [HW-1:0] den;
  logic [7:0]    range_first;
  logic [7:0]    range_last;

  sector_t       sector_next;
  logic [HW-1:0] num_next;
  logic [HW-1:0] den_next;
  logic [HW-1:0] hue_w;

  pipe_t         stg [NSTG];
  logic          vld [NSTG];
  pipe_t         stg_next [NSTG];
  logic          adv;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Hue decode for a write of new_hue.
  always_comb begin
    hue_w = HW'(cfg_data) * HW'(HUE_SCALE);
    if (hue_w <= D120) begin
      if (hue_w < D60) begin
        sector_next = SEC_RED_UP;
        num_next    = hue_w;
        den_next    = D120 - hue_w;
      end else begin
        sector_next = SEC_GREEN_DOWN;
        num_next    = D120 - hue_w;
        den_next    = hue_w;
      end
    end else if (hue_w <= D240) begin
      if (hue_w < D180) begin
        sector_next = SEC_GREEN_UP;
        num_next    = hue_w - D120;
        den_next    = D240 - hue_w;
      end else begin
        sector_next = SEC_BLUE_DOWN;
        num_next    = D240 - hue_w;
        den_next    = hue_w - D120;
      end
    end else begin
      if (hue_w < D300) begin
        sector_next = SEC_BLUE_UP;
        num_next    = hue_w - D240;
        den_next    = D360 - hue_w;
      end else begin
        sector_next = SEC_RED_DOWN;
        num_next    = D360 - hue_w;
        den_next    = hue_w - D240;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sector      <= SEC_RED_UP;
      num         <= '0;
      den         <= D120;
      range_first <= 8'd0;
      range_last  <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NEW_HUE: begin
          sector <= sector_next;
          num    <= num_next;
          den    <= den_next;
        end
        REG_RANGE_FIRST: range_first <= cfg_data;
        REG_RANGE_LAST:  range_last  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 0: range check, max and min of the three channels.
  always_comb begin
    logic [CW-1:0] mx_rg;
    logic [CW-1:0] mn_rg;
    mx_rg = (red_in > green_in) ? red_in : green_in;
    mn_rg = (red_in < green_in) ? red_in : green_in;
    stg_next[0]      = '0;
    stg_next[0].pass = !(entry_index >= range_first && entry_index <= range_last);
    stg_next[0].r    = red_in;
    stg_next[0].g    = green_in;
    stg_next[0].b    = blue_in;
    stg_next[0].mx   = (blue_in > mx_rg) ? blue_in : mx_rg;
    stg_next[0].mn   = (blue_in < mn_rg) ? blue_in : mn_rg;
    stg_next[0].diff = stg_next[0].mx - stg_next[0].mn;
  end

  // Stage 1: scaled numerator of the interpolation.
  always_comb begin
    stg_next[1]     = stg[0];
    stg_next[1].rem = REM_W'(stg[0].diff) * REM_W'(num);
    stg_next[1].q   = '0;
  end

  // Restoring divider; the ratio is at most one, so the quotient fits in QW bits.
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    always_comb begin
      logic [REM_W-1:0] rem;
      logic [REM_W-1:0] dsor;
      logic [QW-1:0]    q;
      rem = stg[j + 1].rem;
      q   = stg[j + 1].q;
      for (int k = 0; k < BPS; k++) begin
        dsor = REM_W'(den) << (QW - 1 - j * BPS - k);
        if (rem >= dsor) begin
          rem = rem - dsor;
          q[QW - 1 - j * BPS - k] = 1'b1;
        end
      end
      stg_next[j + 2]     = stg[j + 1];
      stg_next[j + 2].rem = rem;
      stg_next[j + 2].q   = q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSTG; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) begin
        vld[i] <= vld[i - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NSTG; i++) begin
        stg[i] <= stg_next[i];
      end
    end
  end

  // Output stage: place max, min and the interpolated channel by sector, or pass entries outside the range through.
  logic [CW-1:0] mid;
  logic [CW-1:0] r_new;
  logic [CW-1:0] g_new;
  logic [CW-1:0] b_new;
  pipe_t         last;

  assign last = stg[NSTG - 1];
  assign mid  = CW'(9'(last.mn) + 9'(last.q));

  always_comb begin
    unique case (sector)
      SEC_RED_UP:     begin r_new = last.mx;  g_new = mid;     b_new = last.mn; end
      SEC_GREEN_DOWN: begin r_new = mid;      g_new = last.mx; b_new = last.mn; end
      SEC_GREEN_UP:   begin r_new = last.mn;  g_new = last.mx; b_new = mid;     end
      SEC_BLUE_DOWN:  begin r_new = last.mn;  g_new = mid;     b_new = last.mx; end
      SEC_BLUE_UP:    begin r_new = mid;      g_new = last.mn; b_new = last.mx; end
      SEC_RED_DOWN:   begin r_new = last.mx;  g_new = last.mn; b_new = mid;     end
      default:        begin r_new = last.r;   g_new = last.g;  b_new = last.b;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[NSTG - 1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red_out   <= last.pass ? last.r : r_new;
      green_out <= last.pass ? last.g : g_new;
      blue_out  <= last.pass ? last.b : b_new;
    end
  end

`include "assert_macros.svh"

  `AST_ALWAYS(a_den_nonzero, den != '0, "hue denominator is zero")
  `AST_ALWAYS(a_ratio_le_one, num <= den, "hue ratio exceeds one")
  `AST_ALWAYS(a_mid_in_span, !vld[NSTG - 1] || last.q <= last.diff, "quotient exceeds span")
  `AST_NEXT(a_last_to_out, adv && vld[NSTG - 1], out_valid, "result dropped at output")

endmodule

`default_nettype wire
